FILE: rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types, codes and segment lengths of the I2C master bit engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

   localparam int TickW = 16;
   localparam int LimitW = 16;

   localparam logic [0:0] CSR_UNIT_TICKS = 1'b0;
   localparam logic [0:0] CSR_ACK_LIMIT  = 1'b1;

   localparam logic [TickW-1:0]  UNIT_TICKS_RST = 16'd480;
   localparam logic [LimitW-1:0] ACK_LIMIT_RST  = 16'd1000;

   localparam logic [2:0] FN_NONE     = 3'd0;
   localparam logic [2:0] FN_START    = 3'd1;
   localparam logic [2:0] FN_STOP     = 3'd2;
   localparam logic [2:0] FN_WRITE    = 3'd3;
   localparam logic [2:0] FN_READ     = 3'd4;
   localparam logic [2:0] FN_WAIT_ACK = 3'd5;

   typedef enum logic [3:0] {
      PH_IDLE    = 4'd0,
      PH_ST_A    = 4'd1,
      PH_ST_B    = 4'd2,
      PH_SP_A    = 4'd3,
      PH_SP_B    = 4'd4,
      PH_WR_LO   = 4'd5,
      PH_WR_HI   = 4'd6,
      PH_WR_TL   = 4'd7,
      PH_RD_LO   = 4'd8,
      PH_RD_HI   = 4'd9,
      PH_RD_TL   = 4'd10,
      PH_AK_LO   = 4'd11,
      PH_AK_HI   = 4'd12,
      PH_WA_A    = 4'd13,
      PH_WA_B    = 4'd14,
      PH_WA_POLL = 4'd15
   } phase_type;

   typedef struct packed {
      logic [2:0] func;
      logic [7:0] wr_data;
      logic       send_ack;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rd_data;
      logic       ack_missing;
   } rsp_type;

   typedef struct packed {
      logic [0:0]       index;
      logic [TickW-1:0] wdata;
   } csr_type;

   function automatic logic [2:0] seg_units(phase_type p);
      logic [2:0] u;
      case (p)
         PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B: u = 3'd4;
         PH_WR_LO, PH_WR_HI, PH_WR_TL, PH_RD_LO, PH_RD_HI,
         PH_AK_LO, PH_AK_HI:                  u = 3'd2;
         PH_RD_TL, PH_WA_A, PH_WA_B, PH_WA_POLL: u = 3'd1;
         default:                             u = 3'd0;
      endcase
      return u;
   endfunction

endpackage

FILE: rtl/i2cm_ifs.sv
// ----------------------------------------------------------------------------
// i2cm channel interfaces
// Valid/ready channels for command ticks, results and register writes.
// ----------------------------------------------------------------------------
interface i2cm_req_if;
   import i2cm_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface i2cm_rsp_if;
   import i2cm_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface i2cm_csr_if;
   import i2cm_pkg::*;
   logic    valid;
   logic    ready;
   csr_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/i2c_master_bit_engine_unit.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_unit
// The result of an item is registered and appears in the cycle after it is accepted.
// Throughput: one item per cycle unless a pending result is not taken; one output register holds the result.
// Reset clears the sequencer to idle with both lines released and restores
// unit_ticks to 480 and ack_timeout_limit to 1000.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_unit (
   input  logic clock,
   input  logic reset,
   i2cm_csr_if.sink   csr_if,
   i2cm_req_if.sink   req_if,
   i2cm_rsp_if.source rsp_if
);
   import i2cm_pkg::*;

   logic [TickW-1:0]  unit_ticks_ff;
   logic [LimitW-1:0] ack_limit_ff;

   phase_type         phase_ff, phase_in;
   logic [TickW-1:0]  tick_count_ff, tick_count_in;
   logic [2:0]        unit_count_ff, unit_count_in;
   logic [3:0]        bit_count_ff, bit_count_in;
   logic [7:0]        shift_ff, shift_in;
   logic [LimitW-1:0] wait_count_ff, wait_count_in;
   logic              ack_choice_ff, ack_choice_in;
   logic              scl_ff, scl_in;
   logic              sda_ff, sda_in;
   logic              timeout_ff, timeout_in;
   logic [7:0]        rd_hold_ff, rd_hold_in;
   logic              done_in;

   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   logic              req_fire;
   logic [TickW-1:0]  ut_eff;
   logic [TickW:0]    tick_inc;
   logic              unit_end;
   logic [2:0]        unit_inc;
   logic              seg_end;
   logic [3:0]        bit_inc;
   logic              last_bit;
   logic              limit_hit;
   req_type           rq;

   assign rq        = req_if.data;
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_fire  = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;

   assign ut_eff    = (unit_ticks_ff == '0) ? TickW'(1) : unit_ticks_ff;
   assign tick_inc  = {1'b0, tick_count_ff} + (TickW+1)'(1);
   assign unit_end  = tick_inc >= {1'b0, ut_eff};
   assign unit_inc  = unit_count_ff + 3'd1;
   assign seg_end   = unit_end && (unit_inc >= seg_units(phase_ff));
   assign bit_inc   = bit_count_ff + 4'd1;
   assign last_bit  = bit_inc >= 4'd8;
   assign limit_hit = wait_count_ff >= ack_limit_ff;

   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_IDLE: begin
            case (rq.func)
               FN_START:    phase_in = PH_ST_A;
               FN_STOP:     phase_in = PH_SP_A;
               FN_WRITE:    phase_in = PH_WR_LO;
               FN_READ:     phase_in = PH_RD_LO;
               FN_WAIT_ACK: phase_in = PH_WA_A;
               default:     phase_in = PH_IDLE;
            endcase
         end
         PH_WA_POLL: begin
            if (!rq.sda_in) phase_in = PH_IDLE;
            else if (unit_end && limit_hit) phase_in = PH_SP_A;
         end
         default: begin
            if (seg_end) begin
               case (phase_ff)
                  PH_ST_A:  phase_in = PH_ST_B;
                  PH_ST_B:  phase_in = PH_IDLE;
                  PH_SP_A:  phase_in = PH_SP_B;
                  PH_SP_B:  phase_in = PH_IDLE;
                  PH_WR_LO: phase_in = PH_WR_HI;
                  PH_WR_HI: phase_in = PH_WR_TL;
                  PH_WR_TL: phase_in = last_bit ? PH_IDLE : PH_WR_LO;
                  PH_RD_LO: phase_in = PH_RD_HI;
                  PH_RD_HI: phase_in = PH_RD_TL;
                  PH_RD_TL: phase_in = last_bit ? PH_AK_LO : PH_RD_LO;
                  PH_AK_LO: phase_in = PH_AK_HI;
                  PH_AK_HI: phase_in = PH_IDLE;
                  PH_WA_A:  phase_in = PH_WA_B;
                  PH_WA_B:  phase_in = PH_WA_POLL;
                  default:  phase_in = PH_IDLE;
               endcase
            end
         end
      endcase
   end

   always_comb begin
      if (phase_in != phase_ff) begin
         tick_count_in = '0;
         unit_count_in = '0;
      end else if (phase_ff != PH_IDLE) begin
         tick_count_in = unit_end ? '0 : tick_inc[TickW-1:0];
         unit_count_in = unit_end ? unit_inc : unit_count_ff;
      end else begin
         tick_count_in = tick_count_ff;
         unit_count_in = unit_count_ff;
      end
   end

   always_comb begin
      bit_count_in  = bit_count_ff;
      shift_in      = shift_ff;
      wait_count_in = wait_count_ff;
      ack_choice_in = ack_choice_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;
      timeout_in    = timeout_ff;
      rd_hold_in    = rd_hold_ff;
      done_in       = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (phase_in != PH_IDLE) bit_count_in = '0;
            case (rq.func)
               FN_START: begin
                  scl_in = 1'b1;
                  sda_in = 1'b1;
               end
               FN_STOP: begin
                  scl_in = 1'b1;
                  sda_in = 1'b0;
               end
               FN_WRITE: begin
                  shift_in = rq.wr_data;
                  scl_in   = 1'b0;
                  sda_in   = rq.wr_data[7];
               end
               FN_READ: begin
                  shift_in      = '0;
                  ack_choice_in = rq.send_ack;
                  scl_in        = 1'b0;
                  sda_in        = 1'b1;
               end
               FN_WAIT_ACK: begin
                  timeout_in    = 1'b0;
                  wait_count_in = '0;
                  sda_in        = 1'b1;
               end
               default: ;
            endcase
         end
         PH_WA_POLL: begin
            if (!rq.sda_in) begin
               scl_in     = 1'b0;
               timeout_in = 1'b0;
               done_in    = 1'b1;
            end else if (unit_end) begin
               if (limit_hit) begin
                  timeout_in = 1'b1;
                  scl_in     = 1'b1;
                  sda_in     = 1'b0;
               end else begin
                  wait_count_in = wait_count_ff + LimitW'(1);
               end
            end
         end
         default: begin
            if (seg_end) begin
               case (phase_ff)
                  PH_ST_A: begin
                     scl_in = 1'b1;
                     sda_in = 1'b0;
                  end
                  PH_ST_B, PH_AK_HI: begin
                     scl_in  = 1'b0;
                     done_in = 1'b1;
                  end
                  PH_SP_B: done_in = 1'b1;
                  PH_WR_LO: begin
                     scl_in = 1'b1;
                     sda_in = shift_ff[7];
                  end
                  PH_WR_HI: begin
                     scl_in = 1'b0;
                     sda_in = shift_ff[7];
                  end
                  PH_WR_TL: begin
                     bit_count_in = bit_inc;
                     shift_in     = {shift_ff[6:0], 1'b0};
                     if (last_bit) begin
                        done_in = 1'b1;
                     end else begin
                        scl_in = 1'b0;
                        sda_in = shift_ff[6];
                     end
                  end
                  PH_RD_HI: begin
                     shift_in = {shift_ff[6:0], rq.sda_in};
                     scl_in   = 1'b1;
                     sda_in   = 1'b1;
                  end
                  PH_RD_TL: begin
                     bit_count_in = bit_inc;
                     scl_in       = 1'b0;
                     if (last_bit) begin
                        rd_hold_in = shift_ff;
                        sda_in     = !ack_choice_ff;
                     end else begin
                        sda_in = 1'b1;
                     end
                  end
                  PH_AK_LO: scl_in = 1'b1;
                  PH_SP_A, PH_RD_LO, PH_WA_A: begin
                     scl_in = 1'b1;
                     sda_in = 1'b1;
                  end
                  PH_WA_B: begin
                     scl_in        = 1'b1;
                     sda_in        = 1'b1;
                     wait_count_in = '0;
                  end
                  default: ;
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ticks_ff <= UNIT_TICKS_RST;
         ack_limit_ff  <= ACK_LIMIT_RST;
      end else if (csr_if.valid) begin
         case (csr_if.data.index)
            CSR_UNIT_TICKS: unit_ticks_ff <= csr_if.data.wdata;
            CSR_ACK_LIMIT:  ack_limit_ff  <= csr_if.data.wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         tick_count_ff <= '0;
         unit_count_ff <= '0;
         bit_count_ff  <= '0;
         shift_ff      <= '0;
         wait_count_ff <= '0;
         ack_choice_ff <= 1'b0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         timeout_ff    <= 1'b0;
         rd_hold_ff    <= '0;
      end else if (req_fire) begin
         phase_ff      <= phase_in;
         tick_count_ff <= tick_count_in;
         unit_count_ff <= unit_count_in;
         bit_count_ff  <= bit_count_in;
         shift_ff      <= shift_in;
         wait_count_ff <= wait_count_in;
         ack_choice_ff <= ack_choice_in;
         scl_ff        <= scl_in;
         sda_ff        <= sda_in;
         timeout_ff    <= timeout_in;
         rd_hold_ff    <= rd_hold_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff.scl_out     <= scl_in;
         rsp_data_ff.sda_out     <= sda_in;
         rsp_data_ff.busy_res    <= phase_in != PH_IDLE;
         rsp_data_ff.done_res    <= done_in;
         rsp_data_ff.rd_data     <= rd_hold_in;
         rsp_data_ff.ack_missing <= timeout_in;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_busy_tracks_phase: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_if.data.busy_res == (phase_ff != PH_IDLE))
      else $error("busy flag disagrees with sequencer phase");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> !(rsp_if.data.done_res && rsp_if.data.busy_res))
      else $error("done reported while still busy");

   a_idle_counters_clear: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> (tick_count_ff == '0 && unit_count_ff == '0))
      else $error("timing counters not cleared in idle");

   a_bit_count_range: assert property (@(posedge clock) disable iff (reset)
      bit_count_ff <= 4'd8)
      else $error("bit counter overran a byte");

   a_stall_only_on_full: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> (rsp_valid_ff && !rsp_if.ready))
      else $error("input stalled without a pending result");
`endif

endmodule
